// ===== rtl/agt_pkg.sv =====
// Shared types and constants of the adjacency matrix graph table.
// Holds the command and result codes and the controller/datapath structs.
// No dependencies; every other file imports this package.
package agt_pkg;

  localparam int CMD_W    = 3;
  localparam int VTX_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int STATUS_W = 2;

  // Command codes of an input item.
  localparam logic [CMD_W-1:0] OP_ADD = 3'd0;
  localparam logic [CMD_W-1:0] OP_REM = 3'd1;
  localparam logic [CMD_W-1:0] OP_TST = 3'd2;
  localparam logic [CMD_W-1:0] OP_NBR = 3'd3;
  localparam logic [CMD_W-1:0] OP_BSY = 3'd4;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Which of the two vertices of an edge command selects a matrix row.
  typedef enum logic {
    ROW_A,
    ROW_B
  } agt_row_e;

  // Kind of result item to be loaded into the output register.
  typedef enum logic [2:0] {
    K_OK0,
    K_OK1,
    K_NONE,
    K_BAD,
    K_NBR,
    K_BEST
  } agt_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      latch;
    logic      rd_en;
    agt_row_e  rd_sel;
    logic      wr_en;
    agt_row_e  wr_sel;
    logic      scan_start;
    logic      nb_load;
    logic      nb_shift;
    logic      emit;
    agt_kind_e kind;
  } agt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             a_ok;
    logic             b_ok;
    logic             cnt_zero;
    logic             present;
    logic             row_zero;
    logic             nb_bit;
    logic             nb_last;
    logic             scan_idle;
    logic             out_free;
  } agt_stat_t;

endpackage

// ===== rtl/agt_if.sv =====
// Valid/ready channel interfaces of the adjacency matrix graph table.
// agt_req_if carries command items, agt_rsp_if carries result items.
// Depends on agt_pkg for the field widths.
interface agt_req_if import agt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [VTX_W-1:0]           first_vertex;
  logic [VTX_W-1:0]           second_vertex;
  logic signed [WEIGHT_W-1:0] edge_weight;

  modport source (
    output valid, cmd, first_vertex, second_vertex, edge_weight,
    input  ready
  );
  modport sink (
    input  valid, cmd, first_vertex, second_vertex, edge_weight,
    output ready
  );
endinterface

interface agt_rsp_if import agt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VTX_W-1:0]    answer;
  logic                last_item;

  modport source (
    output valid, status, answer, last_item,
    input  ready
  );
  modport sink (
    input  valid, status, answer, last_item,
    output ready
  );
endinterface

// ===== rtl/agt_ctrl.sv =====
// Controller state machine of the adjacency matrix graph table.
// Sequences row reads, writes, scans and result loads of agt_dp.
// Depends on agt_pkg for the command and status structs.
module agt_ctrl import agt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  agt_stat_t stat_i,
  output agt_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_CHK,
    S_RDB,
    S_WRB,
    S_RESP,
    S_NBS,
    S_BWAIT
  } state_e;

  state_e    state_q, state_d;
  agt_kind_e kind_q, kind_d;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    cmd_o       = '0;
    req_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_RDA;
        end
      end
      S_RDA: begin
        case (stat_i.op) inside
          OP_ADD, OP_REM, OP_TST: begin
            if (stat_i.a_ok && stat_i.b_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = ROW_A;
              state_d      = S_CHK;
            end else begin
              kind_d  = K_BAD;
              state_d = S_RESP;
            end
          end
          OP_NBR: begin
            if (stat_i.a_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = ROW_A;
              state_d      = S_CHK;
            end else begin
              kind_d  = K_BAD;
              state_d = S_RESP;
            end
          end
          OP_BSY: begin
            if (stat_i.cnt_zero) begin
              kind_d  = K_BAD;
              state_d = S_RESP;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_BWAIT;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CHK: begin
        case (stat_i.op)
          OP_ADD: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = ROW_A;
            kind_d       = K_OK0;
            state_d      = S_RDB;
          end
          OP_REM: begin
            if (stat_i.present) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = ROW_A;
              kind_d       = K_OK1;
              state_d      = S_RDB;
            end else begin
              kind_d  = K_NONE;
              state_d = S_RESP;
            end
          end
          OP_TST: begin
            kind_d  = stat_i.present ? K_OK1 : K_NONE;
            state_d = S_RESP;
          end
          default: begin
            if (stat_i.row_zero) begin
              kind_d  = K_NONE;
              state_d = S_RESP;
            end else begin
              cmd_o.nb_load = 1'b1;
              state_d       = S_NBS;
            end
          end
        endcase
      end
      S_RDB: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ROW_B;
        state_d      = S_WRB;
      end
      S_WRB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ROW_B;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = kind_q;
          state_d    = S_IDLE;
        end
      end
      S_NBS: begin
        if (stat_i.nb_bit) begin
          if (stat_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.kind     = K_NBR;
            cmd_o.nb_shift = 1'b1;
            if (stat_i.nb_last) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          cmd_o.nb_shift = 1'b1;
        end
      end
      S_BWAIT: begin
        if (stat_i.scan_idle) begin
          kind_d  = K_BEST;
          state_d = S_RESP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_OK0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // The neighbour walk only runs while set bits remain in the shift register.
  a_nbs_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NBS |-> (stat_i.nb_bit || !stat_i.nb_last))
    else $error("neighbour walk entered with an empty row");

  // An accepted item is always decoded in the following cycle.
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == S_RDA)
    else $error("accepted item not decoded");

endmodule

// ===== rtl/agt_dp.sv =====
// Datapath of the adjacency matrix graph table: row memory with row valid
// bits, command registers, neighbour shifter, degree scan pipeline, output
// register. Depends on agt_pkg; driven by agt_ctrl.
module agt_dp import agt_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [VTX_W-1:0]           cfg_wdata_i,
  input  logic [CMD_W-1:0]           req_cmd_i,
  input  logic [VTX_W-1:0]           req_first_i,
  input  logic [VTX_W-1:0]           req_second_i,
  input  logic signed [WEIGHT_W-1:0] req_weight_i,
  input  agt_cmd_t                   cmd_i,
  output agt_stat_t                  stat_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [STATUS_W-1:0]        out_status_o,
  output logic [VTX_W-1:0]           out_answer_o,
  output logic                       out_last_o
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int VW = (CW > VTX_W) ? CW : VTX_W;
  localparam int PW = 1 << IW;

  function automatic logic [CW-1:0] row_degree(input logic [MAX_VERTICES-1:0] row);
    logic [PW-1:0] padded;
    logic [CW-1:0] acc [PW];
    padded = PW'(row);
    for (int i = 0; i < PW; i++) begin
      acc[i] = CW'(padded[i]);
    end
    for (int s = 1; s < PW; s = s * 2) begin
      for (int i = 0; i < PW; i = i + 2 * s) begin
        acc[i] = acc[i] + acc[i + s];
      end
    end
    return acc[0];
  endfunction

  // Latched command item.
  logic [CMD_W-1:0] op_q;
  logic [VTX_W-1:0] a_q, b_q;
  logic             neg_q;
  logic [CW-1:0]    count_q;

  // Row memory and one valid bit per row; an invalid row reads as zero.
  logic [MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic [MAX_VERTICES-1:0] mem_rd_q;
  logic                    rd_vld_q;
  logic [MAX_VERTICES-1:0] row_rd;

  // Neighbour shifter.
  logic [MAX_VERTICES-1:0] sh_q;
  logic [CW-1:0]           k_q;

  // Degree scan pipeline.
  logic          sc_act_q;
  logic [IW-1:0] ri_q;
  logic          p1_v_q, p2_v_q;
  logic [IW-1:0] p1_idx_q, p2_idx_q;
  logic [CW-1:0] deg_q, best_deg_q;
  logic [IW-1:0] best_q;

  // Output register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [VTX_W-1:0]    answer_q;
  logic                last_q;
  logic [STATUS_W-1:0] status_d;
  logic [VTX_W-1:0]    answer_d;
  logic                last_d;

  logic [IW-1:0]           ia, ib, rd_addr, wr_addr, wr_col, last_row;
  logic                    rd_any, set_val;
  logic [MAX_VERTICES-1:0] wr_row;
  logic [CW-1:0]           count_d;

  assign ia       = IW'(a_q - VTX_W'(1));
  assign ib       = IW'(b_q - VTX_W'(1));
  assign last_row = IW'(count_q - CW'(1));
  assign rd_any   = cmd_i.rd_en || sc_act_q;
  assign rd_addr  = sc_act_q ? ri_q : ((cmd_i.rd_sel == ROW_A) ? ia : ib);
  assign row_rd   = rd_vld_q ? mem_rd_q : '0;
  assign set_val  = (op_q == OP_ADD) && !neg_q;
  assign count_d  = (VW'(cfg_wdata_i) > VW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                          : CW'(cfg_wdata_i);

  always_comb begin
    wr_addr = (cmd_i.wr_sel == ROW_A) ? ia : ib;
    wr_col  = (cmd_i.wr_sel == ROW_A) ? ib : ia;
    wr_row  = row_rd;
    wr_row[wr_col] = set_val;
  end

  always_comb begin
    stat_o.op        = op_q;
    stat_o.a_ok      = (a_q != '0) && (VW'(a_q) <= VW'(count_q));
    stat_o.b_ok      = (b_q != '0) && (VW'(b_q) <= VW'(count_q));
    stat_o.cnt_zero  = (count_q == '0);
    stat_o.present   = row_rd[ib];
    stat_o.row_zero  = (row_rd == '0);
    stat_o.nb_bit    = sh_q[0];
    stat_o.nb_last   = (sh_q[MAX_VERTICES-1:1] == '0);
    stat_o.scan_idle = !sc_act_q && !p1_v_q && !p2_v_q;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    status_d = ST_OK;
    answer_d = '0;
    last_d   = 1'b1;
    case (cmd_i.kind)
      K_OK1:   answer_d = VTX_W'(1);
      K_NONE:  status_d = ST_NONE;
      K_BAD:   status_d = ST_BAD;
      K_NBR: begin
        answer_d = VTX_W'(k_q);
        last_d   = stat_o.nb_last;
      end
      K_BEST:  answer_d = VTX_W'(CW'(best_q) + CW'(1));
      default: answer_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_any) begin
      mem_rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.latch) begin
      op_q  <= req_cmd_i;
      a_q   <= req_first_i;
      b_q   <= req_second_i;
      neg_q <= req_weight_i[WEIGHT_W-1];
    end
    if (cmd_i.nb_load) begin
      sh_q <= row_rd;
      k_q  <= CW'(1);
    end else if (cmd_i.nb_shift) begin
      sh_q <= sh_q >> 1;
      k_q  <= k_q + CW'(1);
    end
    if (sc_act_q) begin
      ri_q <= ri_q + IW'(1);
    end else if (cmd_i.scan_start) begin
      ri_q <= '0;
    end
    p1_idx_q <= ri_q;
    p2_idx_q <= p1_idx_q;
    deg_q    <= row_degree(row_rd);
    if (p2_v_q && ((p2_idx_q == '0) || (deg_q > best_deg_q))) begin
      best_q     <= p2_idx_q;
      best_deg_q <= deg_q;
    end
    if (cmd_i.emit) begin
      status_q <= status_d;
      answer_q <= answer_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      sc_act_q    <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q   <= count_d;
        row_vld_q <= '0;
      end else if (cmd_i.wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_any) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
      if (sc_act_q) begin
        sc_act_q <= (ri_q != last_row);
      end else if (cmd_i.scan_start) begin
        sc_act_q <= 1'b1;
      end
      p1_v_q <= sc_act_q;
      p2_v_q <= p1_v_q;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_answer_o = answer_q;
  assign out_last_o   = last_q;

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> stat_o.out_free)
    else $error("result loaded into a full output register");

  // The busiest result is never loaded while the degree scan still runs.
  a_emit_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_o.scan_idle |-> !cmd_i.emit)
    else $error("result loaded during degree scan");

  // Writing the vertex count empties the whole matrix.
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> row_vld_q == '0)
    else $error("matrix not cleared by vertex count write");

endmodule

// ===== rtl/adjacency_matrix_graph_table.sv =====
// Adjacency matrix graph table: one command item at a time; the next item can be accepted
// in the cycle after the last result of an item is loaded.
// Reset (async, active low) empties the matrix through per-row valid bits at once
// and sets vertex_count to 0; writing vertex_count empties it the same way.
module adjacency_matrix_graph_table import agt_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  agt_req_if.sink          req_i,
  agt_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [VTX_W-1:0] cfg_wdata_i
);

  // The controller and datapath talk only through these two structs.
  agt_cmd_t  cmd;
  agt_stat_t stat;

  // The controller walks each command item through its steps: decode and
  // range check, row read, row update of both mirror entries, neighbour walk
  // or degree scan, and finally loading one result item at a time.
  agt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the matrix, the vertex count, the neighbour shifter,
  // the pipelined degree scan and the output register. The output register
  // lets a new item be taken while the previous result still waits.
  agt_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_cmd_i    (req_i.cmd),
    .req_first_i  (req_i.first_vertex),
    .req_second_i (req_i.second_vertex),
    .req_weight_i (req_i.edge_weight),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (rsp_o.status),
    .out_answer_o (rsp_o.answer),
    .out_last_o   (rsp_o.last_item)
  );

endmodule
